FILE: sv/stt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and helpers of the source text tokenizer.
// ---------------------------------------------------------------------------
package stt_pkg;

  localparam int LINE_NUM_W = 24;
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_PTR_W   = 2;
  localparam int RQ_CNT_W   = 3;
  localparam int MAX_RES    = 3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] TOK_DONE    = 4'd0;
  localparam logic [3:0] TOK_TERM    = 4'd1;
  localparam logic [3:0] TOK_OPEN    = 4'd2;
  localparam logic [3:0] TOK_CLOSE   = 4'd3;
  localparam logic [3:0] TOK_COLON   = 4'd4;
  localparam logic [3:0] TOK_DCOLON  = 4'd5;
  localparam logic [3:0] TOK_EQUAL   = 4'd6;
  localparam logic [3:0] TOK_FATARR  = 4'd7;
  localparam logic [3:0] TOK_ARROW   = 4'd8;
  localparam logic [3:0] TOK_DOLLAR  = 4'd9;
  localparam logic [3:0] TOK_PERCENT = 4'd10;
  localparam logic [3:0] TOK_AMP     = 4'd11;
  localparam logic [3:0] TOK_DECLARE = 4'd12;
  localparam logic [3:0] TOK_STRING  = 4'd13;
  localparam logic [3:0] TOK_NATURAL = 4'd14;
  localparam logic [3:0] TOK_IDENT   = 4'd15;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNEXP    = 3'd1;
  localparam logic [2:0] ERR_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_OPEN_STR = 3'd3;
  localparam logic [2:0] ERR_OPEN_COM = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [2:0] KW_LEN_M1 = 3'd6;

  typedef struct packed {
    logic [1:0]            kind;
    logic [3:0]            ttype;
    logic [7:0]            data;
    logic                  ovf;
    logic [2:0]            err;
    logic [LINE_NUM_W-1:0] line;
    logic                  last;
  } res_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h64;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h63;
      3'd3: ch = 8'h6C;
      3'd4: ch = 8'h61;
      3'd5: ch = 8'h72;
      3'd6: ch = 8'h65;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic restricted(input logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB ||
           c == CH_SLASH || c == CH_LPAR || c == CH_RPAR || c == CH_SEMI ||
           c == CH_DASH || c == CH_DOLLAR || c == CH_PCT || c == CH_EQUAL ||
           c == CH_COLON || c == CH_AMP || c == CH_HASH || c == CH_NUL;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [3:0] ttype,
                                  input logic [7:0] data, input logic [2:0] err,
                                  input logic [LINE_NUM_W-1:0] line);
    res_t r;
    r       = '0;
    r.kind  = kind;
    r.ttype = ttype;
    r.data  = data;
    r.err   = err;
    r.line  = line;
    return r;
  endfunction

endpackage

FILE: sv/stt_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_scan
// Scan state and per-byte result generation (up to three results a byte).
// ---------------------------------------------------------------------------
module stt_scan import stt_pkg::*; #(
  parameter int NATURAL_WIDTH = 64,
  parameter int LINE_WIDTH    = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [7:0]               char_byte,
  output logic [1:0]               push_cnt,
  output res_t                     push_res [MAX_RES],
  output logic [NATURAL_WIDTH-1:0] push_val [MAX_RES]
);

  typedef enum logic [3:0] {
    M_IDLE, M_COLON, M_EQUAL, M_DASH, M_HASH, M_STRING, M_ESCAPE, M_SLASH,
    M_LINECOM, M_BLOCKCOM, M_BLOCKSTAR, M_NATURAL, M_IDENT
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [2:0]               kw_r, kw_nxt;
  logic [NATURAL_WIDTH-1:0] acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [LINE_WIDTH-1:0]    line_r, line_nxt;

  logic [LINE_WIDTH-1:0]    line_inc;
  logic [LINE_WIDTH-1:0]    line_inc2;
  logic [LINE_NUM_W-1:0]    ln_old, ln_new;
  logic [NATURAL_WIDTH+3:0] acc_ext, acc_mul;
  logic [3:0]               digit;
  logic                     is_digit;

  assign line_inc  = (line_r == '1) ? line_r : line_r + 1'b1;
  assign line_inc2 = (line_inc == '1) ? line_inc : line_inc + 1'b1;
  assign ln_old    = LINE_NUM_W'(line_inc);
  assign ln_new    = LINE_NUM_W'(line_inc2);
  assign digit     = char_byte[3:0];
  assign is_digit  = char_byte >= CH_ZERO && char_byte <= CH_NINE;
  assign acc_ext   = (NATURAL_WIDTH+4)'(acc_r);
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + (NATURAL_WIDTH+4)'(digit);

  always_comb begin
    res_t                  r [MAX_RES];
    logic [NATURAL_WIDTH-1:0] v [MAX_RES];
    logic [1:0]            n;
    logic                  do_idle;
    logic                  do_ident;
    logic [LINE_NUM_W-1:0] ln;
    logic [7:0]            esc;

    mode_nxt = mode_r;
    kw_nxt   = kw_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    line_nxt = line_r;
    for (int i = 0; i < MAX_RES; i++) begin
      r[i] = '0;
      v[i] = '0;
    end
    n        = 2'd0;
    do_idle  = 1'b0;
    do_ident = 1'b0;
    ln       = ln_old;
    esc      = CH_NUL;

    if (take) begin
      if (char_byte == CH_NUL) begin
        case (mode_r)
          M_COLON: begin
            r[n] = mk_res(KIND_TOKEN, TOK_COLON, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
          end
          M_EQUAL: begin
            r[n] = mk_res(KIND_TOKEN, TOK_EQUAL, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
          end
          M_DASH, M_HASH: begin
            r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_UNEXP, ln); n = n + 2'd1;
          end
          M_STRING, M_ESCAPE: begin
            r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_OPEN_STR, ln); n = n + 2'd1;
          end
          M_SLASH: begin
            r[n] = mk_res(KIND_DATA, TOK_IDENT, CH_SLASH, ERR_NONE, ln); n = n + 2'd1;
            r[n] = mk_res(KIND_TOKEN, TOK_IDENT, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
          end
          M_BLOCKCOM, M_BLOCKSTAR: begin
            r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_OPEN_COM, ln); n = n + 2'd1;
          end
          M_NATURAL: begin
            r[n] = mk_res(KIND_TOKEN, TOK_NATURAL, CH_NUL, ERR_NONE, ln);
            r[n].ovf = ovf_r;
            v[n] = acc_r;
            n = n + 2'd1;
          end
          M_IDENT: begin
            r[n] = mk_res(KIND_TOKEN, TOK_IDENT, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
          end
          default: begin
          end
        endcase
        r[n] = mk_res(KIND_TOKEN, TOK_DONE, CH_NUL, ERR_NONE, ln);
        n = n + 2'd1;
        mode_nxt = M_IDLE;
        kw_nxt   = '0;
        acc_nxt  = '0;
        ovf_nxt  = 1'b0;
        line_nxt = '0;
      end else begin
        case (mode_r)
          M_COLON: begin
            if (char_byte == CH_COLON) begin
              r[n] = mk_res(KIND_TOKEN, TOK_DCOLON, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              r[n] = mk_res(KIND_TOKEN, TOK_COLON, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_EQUAL: begin
            if (char_byte == CH_GT) begin
              r[n] = mk_res(KIND_TOKEN, TOK_FATARR, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              r[n] = mk_res(KIND_TOKEN, TOK_EQUAL, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_DASH: begin
            if (char_byte == CH_GT) begin
              r[n] = mk_res(KIND_TOKEN, TOK_ARROW, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_UNEXP, ln); n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_HASH: begin
            if (kw_r <= KW_LEN_M1 && char_byte == kw_char(kw_r)) begin
              if (kw_r == KW_LEN_M1) begin
                r[n] = mk_res(KIND_TOKEN, TOK_DECLARE, CH_NUL, ERR_NONE, ln);
                n = n + 2'd1;
                mode_nxt = M_IDLE;
                kw_nxt   = '0;
              end else begin
                kw_nxt = kw_r + 3'd1;
              end
            end else begin
              r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_UNEXP, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
              kw_nxt   = '0;
            end
          end
          M_STRING: begin
            if (char_byte == CH_QUOTE) begin
              r[n] = mk_res(KIND_TOKEN, TOK_STRING, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else if (char_byte == CH_BSLASH) begin
              mode_nxt = M_ESCAPE;
            end else begin
              if (char_byte == CH_LF) begin
                line_nxt = line_inc;
                ln       = ln_new;
              end
              r[n] = mk_res(KIND_DATA, TOK_STRING, char_byte, ERR_NONE, ln); n = n + 2'd1;
            end
          end
          M_ESCAPE: begin
            case (char_byte)
              CH_BSLASH: esc = CH_BSLASH;
              CH_LOW_N:  esc = CH_LF;
              CH_LOW_R:  esc = CH_CR;
              CH_QUOTE:  esc = CH_QUOTE;
              CH_LOW_T:  esc = CH_TAB;
              default:   esc = CH_NUL;
            endcase
            if (esc != CH_NUL) begin
              r[n] = mk_res(KIND_DATA, TOK_STRING, esc, ERR_NONE, ln); n = n + 2'd1;
              mode_nxt = M_STRING;
            end else begin
              r[n] = mk_res(KIND_ERROR, TOK_DONE, CH_NUL, ERR_ESCAPE, ln); n = n + 2'd1;
              mode_nxt = M_IDLE;
            end
          end
          M_SLASH: begin
            if (char_byte == CH_SLASH) begin
              mode_nxt = M_LINECOM;
            end else if (char_byte == CH_STAR) begin
              mode_nxt = M_BLOCKCOM;
            end else begin
              r[n] = mk_res(KIND_DATA, TOK_IDENT, CH_SLASH, ERR_NONE, ln); n = n + 2'd1;
              do_ident = 1'b1;
            end
          end
          M_LINECOM: begin
            if (char_byte == CH_LF) begin
              line_nxt = line_inc;
              mode_nxt = M_IDLE;
            end
          end
          M_BLOCKCOM: begin
            if (char_byte == CH_STAR) mode_nxt = M_BLOCKSTAR;
          end
          M_BLOCKSTAR: begin
            if (char_byte == CH_SLASH) mode_nxt = M_IDLE;
            else if (char_byte != CH_STAR) mode_nxt = M_BLOCKCOM;
          end
          M_NATURAL: begin
            if (is_digit) begin
              if (ovf_r || acc_mul[NATURAL_WIDTH+3:NATURAL_WIDTH] != 4'd0) begin
                acc_nxt = '1;
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_mul[NATURAL_WIDTH-1:0];
              end
            end else begin
              r[n] = mk_res(KIND_TOKEN, TOK_NATURAL, CH_NUL, ERR_NONE, ln);
              r[n].ovf = ovf_r;
              v[n] = acc_r;
              n = n + 2'd1;
              do_idle = 1'b1;
            end
          end
          M_IDENT: do_ident = 1'b1;
          default: do_idle = 1'b1;
        endcase

        if (do_ident) begin
          if (restricted(char_byte)) begin
            r[n] = mk_res(KIND_TOKEN, TOK_IDENT, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            do_idle = 1'b1;
          end else begin
            r[n] = mk_res(KIND_DATA, TOK_IDENT, char_byte, ERR_NONE, ln); n = n + 2'd1;
            mode_nxt = M_IDENT;
          end
        end

        if (do_idle) begin
          mode_nxt = M_IDLE;
          case (char_byte)
            CH_LF: line_nxt = line_inc;
            CH_TAB, CH_SPACE, CH_CR: begin
            end
            CH_SEMI: begin
              r[n] = mk_res(KIND_TOKEN, TOK_TERM, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_LPAR: begin
              r[n] = mk_res(KIND_TOKEN, TOK_OPEN, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_RPAR: begin
              r[n] = mk_res(KIND_TOKEN, TOK_CLOSE, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_DOLLAR: begin
              r[n] = mk_res(KIND_TOKEN, TOK_DOLLAR, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_PCT: begin
              r[n] = mk_res(KIND_TOKEN, TOK_PERCENT, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_AMP: begin
              r[n] = mk_res(KIND_TOKEN, TOK_AMP, CH_NUL, ERR_NONE, ln); n = n + 2'd1;
            end
            CH_COLON: mode_nxt = M_COLON;
            CH_EQUAL: mode_nxt = M_EQUAL;
            CH_DASH:  mode_nxt = M_DASH;
            CH_HASH: begin
              mode_nxt = M_HASH;
              kw_nxt   = '0;
            end
            CH_QUOTE: mode_nxt = M_STRING;
            CH_SLASH: mode_nxt = M_SLASH;
            default: begin
              if (is_digit) begin
                acc_nxt  = NATURAL_WIDTH'(digit);
                ovf_nxt  = 1'b0;
                mode_nxt = M_NATURAL;
              end else begin
                r[n] = mk_res(KIND_DATA, TOK_IDENT, char_byte, ERR_NONE, ln);
                n = n + 2'd1;
                mode_nxt = M_IDENT;
              end
            end
          endcase
        end
      end
      if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    end

    push_cnt = n;
    for (int i = 0; i < MAX_RES; i++) begin
      push_res[i] = r[i];
      push_val[i] = v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      kw_r   <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      line_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      kw_r   <= kw_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

FILE: sv/stt_rq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stt_rq
// Result queue: takes up to three results a cycle, hands out one a cycle while out_ready is high.
// ---------------------------------------------------------------------------
module stt_rq import stt_pkg::*; #(
  parameter int NATURAL_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_cnt,
  input  res_t                     push_res [MAX_RES],
  input  logic [NATURAL_WIDTH-1:0] push_val [MAX_RES],
  output logic                     room,
  output logic                     out_valid,
  input  logic                     out_ready,
  output res_t                     head_res,
  output logic [NATURAL_WIDTH-1:0] head_val
);

  res_t                     q_r [RQ_DEPTH];
  logic [NATURAL_WIDTH-1:0] qv_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]      wp_r, rp_r;
  logic [RQ_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                     pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign room      = cnt_r <= RQ_CNT_W'(RQ_DEPTH - MAX_RES);
  assign head_res  = q_r[rp_r];
  assign head_val  = qv_r[rp_r];
  assign cnt_nxt   = cnt_r + RQ_CNT_W'(push_cnt) - RQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + RQ_PTR_W'(push_cnt);
      rp_r  <= rp_r + RQ_PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        q_r[wp_r + RQ_PTR_W'(i)]  <= push_res[i];
        qv_r[wp_r + RQ_PTR_W'(i)] <= push_val[i];
      end
    end
  end

endmodule

FILE: sv/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial tokenizer: one source byte per request, results one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
// Each accepted byte is scanned in the cycle it arrives and produces zero to
// three results, which go into a four-entry result queue. A byte is taken
// whenever the queue holds at most one result, so one byte per cycle is
// sustained while each byte yields at most one result and the result port is
// ready; the result port, at one result per cycle, sets the rate otherwise.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int NATURAL_WIDTH = 64,
  parameter int LINE_WIDTH    = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_char_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_result_kind,
  output logic [3:0]               out_token_type,
  output logic [7:0]               out_data_byte,
  output logic [NATURAL_WIDTH-1:0] out_natural_value,
  output logic                     out_natural_overflow,
  output logic [2:0]               out_error_code,
  output logic [LINE_NUM_W-1:0]    out_line_number,
  output logic                     out_last_of_run
);

  logic [1:0]               push_cnt;
  res_t                     push_res [MAX_RES];
  logic [NATURAL_WIDTH-1:0] push_val [MAX_RES];
  res_t                     head_res;
  logic                     room;

  assign in_ready = room;

  stt_scan #(
    .NATURAL_WIDTH(NATURAL_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_valid && room),
    .char_byte(in_char_byte),
    .push_cnt (push_cnt),
    .push_res (push_res),
    .push_val (push_val)
  );

  stt_rq #(
    .NATURAL_WIDTH(NATURAL_WIDTH)
  ) u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_res (push_res),
    .push_val (push_val),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_res (head_res),
    .head_val (out_natural_value)
  );

  assign out_result_kind      = head_res.kind;
  assign out_token_type       = head_res.ttype;
  assign out_data_byte        = head_res.data;
  assign out_natural_overflow = head_res.ovf;
  assign out_error_code       = head_res.err;
  assign out_line_number      = head_res.line;
  assign out_last_of_run      = head_res.last;

endmodule

FILE: tb/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// source_text_tokenizer_tb
// Streams source bytes into the tokenizer with random idle bursts on both
// ports and checks every token, data and error result against a predictor.
// ---------------------------------------------------------------------------
module source_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int NW = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [3:0] {
    SC_IDLE, SC_COLON, SC_EQUAL, SC_DASH, SC_HASH, SC_STRING, SC_ESCAPE,
    SC_SLASH, SC_LINECOM, SC_BLOCKCOM, SC_BLOCKSTAR, SC_NATURAL, SC_IDENT
  } scan_state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [3:0]            ttype;
    logic [7:0]            data;
    logic [NW-1:0]         value;
    logic                  ovf;
    logic [2:0]            err;
    logic [LINE_NUM_W-1:0] line;
    logic                  last;
  } token_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [3:0] out_token_type;
  logic [7:0] out_data_byte;
  logic [NW-1:0] out_natural_value;
  logic out_natural_overflow;
  logic [2:0] out_error_code;
  logic [LINE_NUM_W-1:0] out_line_number;
  logic out_last_of_run;

  source_text_tokenizer DUT (.*);

  always #10 clk = ~clk;

  scan_state_e  sc_mode;
  logic [2:0]   kw_idx;
  logic [NW-1:0] acc;
  logic         acc_ovf;
  logic [LINE_NUM_W-1:0] lines;
  token_res_t   expected_tokens[$];
  token_res_t   step_res[$];
  int           errors = 0;
  int           idle_cycles = 0;
  bit           quiet = 0;

  function automatic logic [7:0] keyword_at(input logic [2:0] i);
    logic [7:0] s [7];
    s = '{8'h64, 8'h65, 8'h63, 8'h6C, 8'h61, 8'h72, 8'h65};
    return s[i];
  endfunction

  function automatic bit is_stop(input logic [7:0] c);
    return c inside {CH_SPACE, CH_CR, CH_LF, CH_TAB, CH_SLASH, CH_LPAR, CH_RPAR,
                     CH_SEMI, CH_DASH, CH_DOLLAR, CH_PCT, CH_EQUAL, CH_COLON,
                     CH_AMP, CH_HASH, CH_NUL};
  endfunction

  task automatic push(input logic [1:0] k, input logic [3:0] t, input logic [7:0] d,
                      input logic [NW-1:0] v, input logic o, input logic [2:0] e);
    token_res_t r;
    r.kind = k; r.ttype = t; r.data = d; r.value = v; r.ovf = o; r.err = e;
    r.line = (lines == '1) ? lines : lines + 1'b1;
    r.last = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic count_newline();
    if (lines != '1) lines++;
  endtask

  task automatic scan_between(input logic [7:0] c);
    sc_mode = SC_IDLE;
    case (c)
      CH_LF: count_newline();
      CH_TAB, CH_SPACE, CH_CR: ;
      CH_SEMI: push(KIND_TOKEN, TOK_TERM, 0, 0, 0, ERR_NONE);
      CH_LPAR: push(KIND_TOKEN, TOK_OPEN, 0, 0, 0, ERR_NONE);
      CH_RPAR: push(KIND_TOKEN, TOK_CLOSE, 0, 0, 0, ERR_NONE);
      CH_DOLLAR: push(KIND_TOKEN, TOK_DOLLAR, 0, 0, 0, ERR_NONE);
      CH_PCT: push(KIND_TOKEN, TOK_PERCENT, 0, 0, 0, ERR_NONE);
      CH_AMP: push(KIND_TOKEN, TOK_AMP, 0, 0, 0, ERR_NONE);
      CH_COLON: sc_mode = SC_COLON;
      CH_EQUAL: sc_mode = SC_EQUAL;
      CH_DASH: sc_mode = SC_DASH;
      CH_HASH: begin sc_mode = SC_HASH; kw_idx = 0; end
      CH_QUOTE: sc_mode = SC_STRING;
      CH_SLASH: sc_mode = SC_SLASH;
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          acc = c - CH_ZERO; acc_ovf = 0; sc_mode = SC_NATURAL;
        end else begin
          push(KIND_DATA, TOK_IDENT, c, 0, 0, ERR_NONE); sc_mode = SC_IDENT;
        end
      end
    endcase
  endtask

  task automatic scan_ident(input logic [7:0] c);
    if (is_stop(c)) begin
      push(KIND_TOKEN, TOK_IDENT, 0, 0, 0, ERR_NONE);
      scan_between(c);
    end else begin
      push(KIND_DATA, TOK_IDENT, c, 0, 0, ERR_NONE);
      sc_mode = SC_IDENT;
    end
  endtask

  task automatic predict_byte(input logic [7:0] c);
    logic [7:0] esc;
    logic [NW-1:0] d;
    step_res.delete();
    if (c == CH_NUL) begin
      case (sc_mode)
        SC_COLON: push(KIND_TOKEN, TOK_COLON, 0, 0, 0, ERR_NONE);
        SC_EQUAL: push(KIND_TOKEN, TOK_EQUAL, 0, 0, 0, ERR_NONE);
        SC_DASH, SC_HASH: push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_UNEXP);
        SC_STRING, SC_ESCAPE: push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_OPEN_STR);
        SC_SLASH: begin
          push(KIND_DATA, TOK_IDENT, CH_SLASH, 0, 0, ERR_NONE);
          push(KIND_TOKEN, TOK_IDENT, 0, 0, 0, ERR_NONE);
        end
        SC_BLOCKCOM, SC_BLOCKSTAR: push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_OPEN_COM);
        SC_NATURAL: push(KIND_TOKEN, TOK_NATURAL, 0, acc, acc_ovf, ERR_NONE);
        SC_IDENT: push(KIND_TOKEN, TOK_IDENT, 0, 0, 0, ERR_NONE);
        default: ;
      endcase
      push(KIND_TOKEN, TOK_DONE, 0, 0, 0, ERR_NONE);
      sc_mode = SC_IDLE; kw_idx = 0; acc = 0; acc_ovf = 0; lines = 0;
    end else begin
      case (sc_mode)
        SC_COLON:
          if (c == CH_COLON) begin
            push(KIND_TOKEN, TOK_DCOLON, 0, 0, 0, ERR_NONE); sc_mode = SC_IDLE;
          end else begin
            push(KIND_TOKEN, TOK_COLON, 0, 0, 0, ERR_NONE); scan_between(c);
          end
        SC_EQUAL:
          if (c == CH_GT) begin
            push(KIND_TOKEN, TOK_FATARR, 0, 0, 0, ERR_NONE); sc_mode = SC_IDLE;
          end else begin
            push(KIND_TOKEN, TOK_EQUAL, 0, 0, 0, ERR_NONE); scan_between(c);
          end
        SC_DASH:
          if (c == CH_GT) begin
            push(KIND_TOKEN, TOK_ARROW, 0, 0, 0, ERR_NONE); sc_mode = SC_IDLE;
          end else begin
            push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_UNEXP); scan_between(c);
          end
        SC_HASH:
          if (kw_idx < 7 && c == keyword_at(kw_idx)) begin
            kw_idx++;
            if (kw_idx >= 7) begin
              push(KIND_TOKEN, TOK_DECLARE, 0, 0, 0, ERR_NONE);
              sc_mode = SC_IDLE; kw_idx = 0;
            end
          end else begin
            push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_UNEXP);
            sc_mode = SC_IDLE; kw_idx = 0;
          end
        SC_STRING:
          if (c == CH_QUOTE) begin
            push(KIND_TOKEN, TOK_STRING, 0, 0, 0, ERR_NONE); sc_mode = SC_IDLE;
          end else if (c == CH_BSLASH) sc_mode = SC_ESCAPE;
          else begin
            if (c == CH_LF) count_newline();
            push(KIND_DATA, TOK_STRING, c, 0, 0, ERR_NONE);
          end
        SC_ESCAPE: begin
          case (c)
            CH_BSLASH: esc = CH_BSLASH;
            CH_LOW_N: esc = CH_LF;
            CH_LOW_R: esc = CH_CR;
            CH_QUOTE: esc = CH_QUOTE;
            CH_LOW_T: esc = CH_TAB;
            default: esc = CH_NUL;
          endcase
          if (esc != CH_NUL) begin
            push(KIND_DATA, TOK_STRING, esc, 0, 0, ERR_NONE); sc_mode = SC_STRING;
          end else begin
            push(KIND_ERROR, TOK_DONE, 0, 0, 0, ERR_ESCAPE); sc_mode = SC_IDLE;
          end
        end
        SC_SLASH:
          if (c == CH_SLASH) sc_mode = SC_LINECOM;
          else if (c == CH_STAR) sc_mode = SC_BLOCKCOM;
          else begin
            push(KIND_DATA, TOK_IDENT, CH_SLASH, 0, 0, ERR_NONE); scan_ident(c);
          end
        SC_LINECOM:
          if (c == CH_LF) begin count_newline(); sc_mode = SC_IDLE; end
        SC_BLOCKCOM:
          if (c == CH_STAR) sc_mode = SC_BLOCKSTAR;
        SC_BLOCKSTAR:
          if (c == CH_SLASH) sc_mode = SC_IDLE;
          else if (c != CH_STAR) sc_mode = SC_BLOCKCOM;
        SC_NATURAL:
          if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            if (acc_ovf || acc > ({NW{1'b1}} - d) / 10) begin
              acc = '1; acc_ovf = 1;
            end else acc = acc * 10 + d;
          end else begin
            push(KIND_TOKEN, TOK_NATURAL, 0, acc, acc_ovf, ERR_NONE);
            scan_between(c);
          end
        SC_IDENT: scan_ident(c);
        default: scan_between(c);
      endcase
    end
    if (step_res.size() > 0) step_res[$].last = 1'b1;
    foreach (step_res[i]) expected_tokens.push_back(step_res[i]);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(c);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // result checker
  always @(posedge clk) begin
    token_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) report_mismatch("unexpected result");
      else begin
        e = expected_tokens.pop_front();
        if (out_result_kind !== e.kind) report_mismatch("result_kind");
        if (out_token_type !== e.ttype) report_mismatch("token_type");
        if (out_data_byte !== e.data) report_mismatch("data_byte");
        if (out_natural_value !== e.value) report_mismatch("natural_value");
        if (out_natural_overflow !== e.ovf) report_mismatch("natural_overflow");
        if (out_error_code !== e.err) report_mismatch("error_code");
        if (out_line_number !== e.line) report_mismatch("line_number");
        if (out_last_of_run !== e.last) report_mismatch("last_of_run");
      end
    end
  end

  // result-side stalls
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_punctuation();
    send_text(";()$%&: :: = => -> -x");
    send_byte(CH_NUL);
  endtask

  task automatic test_keyword_and_strings();
    send_text("#declare #decx\n#de\"a\\n\\\\\\r\\\"\\tb\"\"\\q");
    send_byte(CH_NUL);
    send_text("\"open");
    send_byte(CH_NUL);
  endtask

  task automatic test_comments_and_numbers();
    send_text("// c\n/* x\n**/ /a /* open");
    send_byte(CH_NUL);
    send_text("18446744073709551615 18446744073709551616 0 /");
    send_byte(CH_NUL);
    send_text("id\377\200");
    send_byte(CH_NUL);
  endtask

  task automatic test_random_text();
    string frags [20];
    int n;
    frags = '{";", "(", ")", ":", "::", "=", "=>", "->", "-", "$", "%", "&",
              "#declare", "#decl", "\"s\\t\"", "42", "// x\n", "/* a */", " ", "\n"};
    for (int i = 0; i < 88; i++) begin
      if (i == 66) quiet = 1;
      n = $urandom_range(0, 9);
      if (n < 6) send_text(frags[$urandom_range(0, 19)]);
      else if (n < 8) send_byte(8'($urandom_range(1, 255)));
      else if (n == 8) send_text("abc1");
      else send_byte(CH_NUL);
    end
    send_byte(CH_NUL);
  endtask

  initial begin
    sc_mode = SC_IDLE; kw_idx = 0; acc = 0; acc_ovf = 0; lines = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_punctuation();
    test_keyword_and_strings();
    test_comments_and_numbers();
    test_random_text();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
sv/stt_pkg.sv
sv/stt_scan.sv
sv/stt_rq.sv
sv/source_text_tokenizer.sv
tb/source_text_tokenizer_tb.sv
